// ===== sv/roi_gradient_focus_measure_top_defines.svh =====
// Assertion macros for the focus measure block.
`ifndef ROI_GRADIENT_FOCUS_MEASURE_TOP_DEFINES_SVH
`define ROI_GRADIENT_FOCUS_MEASURE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RGFM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rgfm: property failed");
`define RGFM_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rgfm: forbidden condition seen");
`else
`define RGFM_ASSERT(label, prop)
`define RGFM_ASSERT_NEVER(label, cond)
`endif
`endif

// ===== sv/rgfm_pkg.sv =====
package rgfm_pkg;

  localparam int MAX_ROW_LENGTH_DFLT = 4096;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 12;
  localparam int LEN_W   = 13;
  localparam int SCORE_W = 40;
  localparam int ADD_W   = 9;

  localparam logic [COORD_W-1:0] ROW_MAX = 12'hFFF;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_BOTTOM = 3'd4;

  localparam logic [LEN_W-1:0]   ROW_LENGTH_RST = 13'd640;
  localparam logic [COORD_W-1:0] ROI_LEFT_RST   = 12'd0;
  localparam logic [COORD_W-1:0] ROI_TOP_RST    = 12'd0;
  localparam logic [COORD_W-1:0] ROI_RIGHT_RST  = 12'd639;
  localparam logic [COORD_W-1:0] ROI_BOTTOM_RST = 12'd479;

  typedef struct packed {
    logic qualify;
    logic first;
    logic last;
  } gfm_ctl_t;

endpackage

// ===== sv/rgfm_linestore.sv =====
module rgfm_linestore #(
  parameter int DEPTH = rgfm_pkg::MAX_ROW_LENGTH_DFLT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [AW-1:0]            waddr,
  input  logic [rgfm_pkg::PIX_W-1:0] wdata,
  input  logic [AW-1:0]            raddr_a,
  input  logic [AW-1:0]            raddr_b,
  output logic [rgfm_pkg::PIX_W-1:0] rdata_a_r,
  output logic [rgfm_pkg::PIX_W-1:0] rdata_b_r
);

  logic [rgfm_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      mem[waddr] <= wdata;
      rdata_a_r  <= mem[raddr_a];
      rdata_b_r  <= mem[raddr_b];
    end
  end

endmodule

// ===== sv/rgfm_position.sv =====
module rgfm_position #(
  parameter int MAX_ROW_LENGTH = rgfm_pkg::MAX_ROW_LENGTH_DFLT,
  localparam int AW = $clog2(MAX_ROW_LENGTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         first,
  input  logic                         last,
  input  logic [rgfm_pkg::LEN_W-1:0]   row_length,
  input  logic [rgfm_pkg::COORD_W-1:0] roi_left,
  input  logic [rgfm_pkg::COORD_W-1:0] roi_top,
  input  logic [rgfm_pkg::COORD_W-1:0] roi_right,
  input  logic [rgfm_pkg::COORD_W-1:0] roi_bottom,
  output logic [AW-1:0]                wr_addr,
  output logic [AW-1:0]                rd_addr_b,
  output rgfm_pkg::gfm_ctl_t           ctl
);

  localparam int CW = (AW > rgfm_pkg::COORD_W ? AW : rgfm_pkg::COORD_W) + 2;
  localparam logic [CW-1:0] MAX_LEN = CW'(MAX_ROW_LENGTH);

  logic [AW-1:0]                col_r, col_nxt;
  logic [rgfm_pkg::COORD_W-1:0] row_r, row_nxt;
  logic [rgfm_pkg::COORD_W-1:0] row_cur;
  logic [CW-1:0]                len_w, c0_w, c_w, c1_w, r_w;

  always_comb begin
    if (row_length == '0 || CW'(row_length) > MAX_LEN) begin
      len_w = MAX_LEN;
    end else begin
      len_w = CW'(row_length);
    end
    c0_w    = first ? '0 : CW'(col_r);
    c_w     = (c0_w >= len_w) ? '0 : c0_w;
    c1_w    = c_w + CW'(1);
    row_cur = first ? '0 : row_r;
    r_w     = CW'(row_cur);

    ctl.first   = first;
    ctl.last    = last;
    ctl.qualify = (row_cur != '0) &&
                  (r_w - CW'(1) >= CW'(roi_top)) &&
                  (r_w + CW'(1) <= CW'(roi_bottom)) &&
                  (c_w >= CW'(roi_left)) &&
                  (c_w + CW'(2) <= CW'(roi_right)) &&
                  (c1_w < len_w);

    wr_addr   = c_w[AW-1:0];
    rd_addr_b = (c1_w == MAX_LEN) ? '0 : c1_w[AW-1:0];

    if (c1_w >= len_w) begin
      col_nxt = '0;
      row_nxt = (row_cur != rgfm_pkg::ROW_MAX) ? row_cur + 1'b1 : row_cur;
    end else begin
      col_nxt = c1_w[AW-1:0];
      row_nxt = row_cur;
    end
    if (last) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== sv/rgfm_accum.sv =====
module rgfm_accum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  rgfm_pkg::gfm_ctl_t           ctl_in,
  input  logic [rgfm_pkg::PIX_W-1:0]   pixel_in,
  input  logic [rgfm_pkg::PIX_W-1:0]   prev_a,
  input  logic [rgfm_pkg::PIX_W-1:0]   prev_b,
  input  logic                         res_stall,
  output logic                         res_valid_r,
  output logic [rgfm_pkg::SCORE_W-1:0] res_score_r,
  output logic                         blocked
);

  logic                         vb_r;
  rgfm_pkg::gfm_ctl_t           ctl_r;
  logic [rgfm_pkg::PIX_W-1:0]   pix_r;
  logic [rgfm_pkg::SCORE_W-1:0] score_r, score_nxt;
  logic [rgfm_pkg::SCORE_W-1:0] base_w, sat_w;
  logic [rgfm_pkg::SCORE_W:0]   sum_w;
  logic [rgfm_pkg::PIX_W-1:0]   d_ba, d_bp;
  logic [rgfm_pkg::ADD_W-1:0]   add_w;
  logic                         advance;

  always_comb begin
    d_ba   = (prev_b > prev_a) ? prev_b - prev_a : prev_a - prev_b;
    d_bp   = (prev_b > pix_r) ? prev_b - pix_r : pix_r - prev_b;
    add_w  = {1'b0, d_ba} + {1'b0, d_bp};
    base_w = ctl_r.first ? '0 : score_r;
    sum_w  = {1'b0, base_w} + (rgfm_pkg::SCORE_W + 1)'(add_w);
    sat_w  = sum_w[rgfm_pkg::SCORE_W] ? '1 : sum_w[rgfm_pkg::SCORE_W-1:0];
    score_nxt = ctl_r.qualify ? sat_w : base_w;
  end

  assign blocked = vb_r && ctl_r.last && res_valid_r && res_stall;
  assign advance = vb_r && !blocked;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r        <= 1'b0;
      ctl_r       <= '0;
      score_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (load) begin
        vb_r  <= 1'b1;
        ctl_r <= ctl_in;
      end else if (advance) begin
        vb_r <= 1'b0;
      end
      if (advance) begin
        score_r <= ctl_r.last ? '0 : score_nxt;
      end
      if (advance && ctl_r.last) begin
        res_valid_r <= 1'b1;
      end else if (!res_stall) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_r <= pixel_in;
    end
    if (advance && ctl_r.last) begin
      res_score_r <= score_nxt;
    end
  end

endmodule

// ===== sv/roi_gradient_focus_measure_top.sv =====
// Gradient-sum focus measure over a region of interest.
// Input channel: one grey pixel per request in raster order, with flags for
// the first pixel (restarts position and score) and the last pixel of a frame.
// Output channel: one 40-bit saturating focus score per frame, sent for the
// request that carries the last-of-frame flag.
// Configuration: row length and region bounds through cfg_write/cfg_index/
// cfg_data; write them only while no pixel is in flight.
// Throughput: one pixel per cycle unless in_stall is high. The line store is
// read at two addresses and written at one on the accepting edge, so no
// pixel waits on memory. Path: accumulate stage, then output register.
// Stall: a pending score sits in the output register; pixels keep flowing.
// in_stall rises only when a second frame end reaches the accumulate stage
// while the previous score is still held by out_stall.
// Reset: positions, score and configuration registers return to defaults
// (row length 640, region 0..639 x 0..479). The line store is not cleared;
// each row is written before the next row reads it.
`include "roi_gradient_focus_measure_top_defines.svh"

module roi_gradient_focus_measure_top #(
  parameter int MAX_ROW_LENGTH = rgfm_pkg::MAX_ROW_LENGTH_DFLT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rgfm_pkg::PIX_W-1:0]      in_pixel,
  input  logic                            in_first_of_frame,
  input  logic                            in_last_of_frame,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rgfm_pkg::SCORE_W-1:0]    out_focus_score,
  input  logic                            cfg_write,
  input  logic [rgfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgfm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_ROW_LENGTH);

  logic [rgfm_pkg::LEN_W-1:0]   row_length_r;
  logic [rgfm_pkg::COORD_W-1:0] roi_left_r, roi_top_r, roi_right_r, roi_bottom_r;

  logic                       accept;
  logic                       blocked;
  logic [AW-1:0]              wr_addr, rd_addr_b;
  rgfm_pkg::gfm_ctl_t         ctl;
  logic [rgfm_pkg::PIX_W-1:0] prev_a, prev_b;

  assign in_stall = blocked;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= rgfm_pkg::ROW_LENGTH_RST;
      roi_left_r   <= rgfm_pkg::ROI_LEFT_RST;
      roi_top_r    <= rgfm_pkg::ROI_TOP_RST;
      roi_right_r  <= rgfm_pkg::ROI_RIGHT_RST;
      roi_bottom_r <= rgfm_pkg::ROI_BOTTOM_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rgfm_pkg::CFG_ROW_LENGTH: row_length_r <= cfg_data;
        rgfm_pkg::CFG_ROI_LEFT:   roi_left_r   <= cfg_data[rgfm_pkg::COORD_W-1:0];
        rgfm_pkg::CFG_ROI_TOP:    roi_top_r    <= cfg_data[rgfm_pkg::COORD_W-1:0];
        rgfm_pkg::CFG_ROI_RIGHT:  roi_right_r  <= cfg_data[rgfm_pkg::COORD_W-1:0];
        rgfm_pkg::CFG_ROI_BOTTOM: roi_bottom_r <= cfg_data[rgfm_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  rgfm_position #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
  ) u_position (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .first      (in_first_of_frame),
    .last       (in_last_of_frame),
    .row_length (row_length_r),
    .roi_left   (roi_left_r),
    .roi_top    (roi_top_r),
    .roi_right  (roi_right_r),
    .roi_bottom (roi_bottom_r),
    .wr_addr    (wr_addr),
    .rd_addr_b  (rd_addr_b),
    .ctl        (ctl)
  );

  rgfm_linestore #(
    .DEPTH(MAX_ROW_LENGTH)
  ) u_linestore (
    .clk       (clk),
    .en        (accept),
    .waddr     (wr_addr),
    .wdata     (in_pixel),
    .raddr_a   (wr_addr),
    .raddr_b   (rd_addr_b),
    .rdata_a_r (prev_a),
    .rdata_b_r (prev_b)
  );

  rgfm_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (accept),
    .ctl_in      (ctl),
    .pixel_in    (in_pixel),
    .prev_a      (prev_a),
    .prev_b      (prev_b),
    .res_stall   (out_stall),
    .res_valid_r (out_valid),
    .res_score_r (out_focus_score),
    .blocked     (blocked)
  );

  `RGFM_ASSERT_NEVER(a_stall_needs_held_score, in_stall && !(out_valid && out_stall))
  `RGFM_ASSERT(a_score_follows_last, in_valid && !in_stall && in_last_of_frame |=> ##1 out_valid)

endmodule

// ===== dv/rgfm_score_checker.sv =====
`timescale 1ns / 100ps

module rgfm_score_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [rgfm_pkg::PIX_W-1:0]   in_pixel,
  input  logic                         in_first_of_frame,
  input  logic                         in_last_of_frame,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [rgfm_pkg::SCORE_W-1:0] out_focus_score,
  input  logic                         cfg_write,
  input  logic [rgfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgfm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                           error_count,
  output int                           scores_pending,
  output int                           scores_seen
);
  import rgfm_pkg::*;

  localparam int LINE_DEPTH = MAX_ROW_LENGTH_DFLT;
  localparam logic [SCORE_W-1:0] SCORE_TOP = {SCORE_W{1'b1}};

  logic [LEN_W-1:0]   row_length_q;
  logic [COORD_W-1:0] roi_left_q;
  logic [COORD_W-1:0] roi_top_q;
  logic [COORD_W-1:0] roi_right_q;
  logic [COORD_W-1:0] roi_bottom_q;

  logic [PIX_W-1:0]   line_buf [LINE_DEPTH];
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [SCORE_W-1:0] score_acc;
  logic [SCORE_W-1:0] expected_scores [$];
  int                 errors;
  int                 seen;

  task automatic take_pixel(input logic [PIX_W-1:0] pix, input logic first, input logic last);
    int unsigned len;
    int unsigned c;
    int unsigned r;
    int unsigned a;
    int unsigned b;
    int unsigned add;
    logic [SCORE_W:0] wide_sum;
    len = (row_length_q == 0 || row_length_q > LINE_DEPTH) ? LINE_DEPTH : row_length_q;
    if (first) begin
      col_pos   = 0;
      row_pos   = 0;
      score_acc = '0;
    end
    if (col_pos >= len) col_pos = 0;
    c = col_pos;
    if (row_pos >= 1) begin
      r = row_pos - 1;
      if (r >= roi_top_q && r + 2 <= roi_bottom_q && c >= roi_left_q &&
          c + 2 <= roi_right_q && c + 1 < len) begin
        a = line_buf[c];
        b = line_buf[c + 1];
        add = ((b > a) ? b - a : a - b) + ((b > pix) ? b - pix : pix - b);
        wide_sum = score_acc + add;
        score_acc = wide_sum[SCORE_W] ? SCORE_TOP : wide_sum[SCORE_W-1:0];
      end
    end
    line_buf[c % LINE_DEPTH] = pix;
    col_pos = c + 1;
    if (col_pos >= len) begin
      col_pos = 0;
      if (row_pos < ROW_MAX) row_pos++;
    end
    if (last) begin
      expected_scores.push_back(score_acc);
      col_pos   = 0;
      row_pos   = 0;
      score_acc = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      row_length_q = ROW_LENGTH_RST;
      roi_left_q   = ROI_LEFT_RST;
      roi_top_q    = ROI_TOP_RST;
      roi_right_q  = ROI_RIGHT_RST;
      roi_bottom_q = ROI_BOTTOM_RST;
      col_pos      = 0;
      row_pos      = 0;
      score_acc    = '0;
      expected_scores.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ROW_LENGTH: row_length_q = cfg_data[LEN_W-1:0];
          CFG_ROI_LEFT:   roi_left_q   = cfg_data[COORD_W-1:0];
          CFG_ROI_TOP:    roi_top_q    = cfg_data[COORD_W-1:0];
          CFG_ROI_RIGHT:  roi_right_q  = cfg_data[COORD_W-1:0];
          CFG_ROI_BOTTOM: roi_bottom_q = cfg_data[COORD_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        seen++;
        if (expected_scores.size() == 0) begin
          errors++;
          $error("focus_score: expected none, actual %0d", out_focus_score);
        end else begin
          if (out_focus_score !== expected_scores[0]) begin
            errors++;
            $error("focus_score: expected %0d, actual %0d", expected_scores[0],
                   out_focus_score);
          end
          void'(expected_scores.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        take_pixel(in_pixel, in_first_of_frame, in_last_of_frame);
      end
    end
    error_count    <= errors;
    scores_pending <= expected_scores.size();
    scores_seen    <= seen;
  end

endmodule

// ===== dv/tb_roi_gradient_focus_measure_top.sv =====
`timescale 1ns / 100ps

module tb_roi_gradient_focus_measure_top;
  import rgfm_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PIXELS = 1350;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic [PIX_W-1:0]      in_pixel = '0;
  logic                  in_first_of_frame = 1'b0;
  logic                  in_last_of_frame = 1'b0;
  logic                  out_stall = 1'b0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ROW_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic [SCORE_W-1:0]    out_focus_score;

  int error_count;
  int scores_pending;
  int scores_seen;
  int send_idle_pct = 25;
  int recv_idle_pct = 86;
  int hold_asks = 0;
  int holds_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int backpressure_cycles = 0;
  int pixels_sent = 0;
  int settings_used = 0;

  always #6 clk = ~clk;

  roi_gradient_focus_measure_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .in_first_of_frame (in_first_of_frame),
    .in_last_of_frame  (in_last_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_focus_score   (out_focus_score),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  rgfm_score_checker score_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .in_first_of_frame (in_first_of_frame),
    .in_last_of_frame  (in_last_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_focus_score   (out_focus_score),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .error_count       (error_count),
    .scores_pending    (scores_pending),
    .scores_seen       (scores_seen)
  );

  // hold off for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (holds_done != hold_asks) begin
      holds_done = hold_asks;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_n && in_valid && in_stall) backpressure_cycles <= backpressure_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("roi_gradient_focus_measure_top: mismatch");
      $finish;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic first, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_pixel          <= pix;
    in_first_of_frame <= first;
    in_last_of_frame  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic send_frame(input int unsigned npix, input bit mark_first, input bit mark_last,
                            input bit noisy);
    logic [PIX_W-1:0] pix;
    logic first;
    logic last;
    for (int unsigned i = 0; i < npix; i++) begin
      pix = $urandom_range(255);
      if ($urandom_range(9) == 0) pix = $urandom_range(1) ? '1 : '0;
      first = (i == 0) ? mark_first : (noisy && $urandom_range(299) == 0);
      last = (i == npix - 1) ? mark_last : (noisy && $urandom_range(299) == 0);
      send_pixel(pix, first, last);
    end
  endtask

  // drop valid and wait for every pending score
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scores_pending != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_region(input int unsigned len, input int unsigned left,
                            input int unsigned top, input int unsigned right,
                            input int unsigned bottom);
    write_reg(CFG_ROW_LENGTH, len);
    write_reg(CFG_ROI_LEFT, left);
    write_reg(CFG_ROI_TOP, top);
    write_reg(CFG_ROI_RIGHT, right);
    write_reg(CFG_ROI_BOTTOM, bottom);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic random_phase();
    int unsigned len;
    int unsigned span;
    int unsigned nframes;
    int unsigned npix;
    bit wide_row;
    wide_row = ($urandom_range(9) == 0);
    if (wide_row) begin
      case ($urandom_range(2))
        0: len = 0;
        1: len = MAX_ROW_LENGTH_DFLT;
        default: len = $urandom_range(MAX_ROW_LENGTH_DFLT + 1, 8191);
      endcase
      span = MAX_ROW_LENGTH_DFLT;
    end else begin
      len = ($urandom_range(4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      span = len;
    end
    if ($urandom_range(6) == 0) begin
      set_region(len, $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                 $urandom_range(4095));
    end else begin
      set_region(len, $urandom_range(span), $urandom_range(2), $urandom_range(span + 1),
                 $urandom_range(6));
    end
    if ($urandom_range(11) == 0) hold_asks++;
    nframes = $urandom_range(1, 4);
    for (int unsigned f = 0; f < nframes; f++) begin
      if (wide_row) npix = $urandom_range(1, 60);
      else npix = $urandom_range(1, 5) * span + $urandom_range(span - 1);
      send_frame(npix, $urandom_range(99) < 85, (f == nframes - 1) || ($urandom_range(19) != 0),
                 1'b1);
      if ($urandom_range(9) == 0) drain();
    end
    settle();
  endtask

  initial begin
    logic [PIX_W-1:0] grid [9];
    int random_start;
    int random_done;
    grid = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, one pixel carrying both frame flags
    send_pixel(8'hA5, 1'b1, 1'b1);
    settle();

    set_region(3, 0, 0, 4095, 4095);
    for (int i = 0; i < 9; i++) send_pixel(grid[i], i == 0, i == 8);
    send_frame(6, 1'b0, 1'b1, 1'b0);
    hold_asks++;
    repeat (12) send_frame(6, 1'b1, 1'b1, 1'b0);
    settle();

    set_region(3, 0, 0, 1, 4095);
    send_frame(9, 1'b1, 1'b1, 1'b0);
    settle();
    set_region(3, 4095, 4095, 0, 0);
    send_frame(9, 1'b1, 1'b1, 1'b0);
    settle();

    set_region(0, 0, 0, 4095, 4095);
    send_frame(24, 1'b1, 1'b1, 1'b0);
    settle();
    set_region(8191, 0, 0, 4095, 4095);
    send_frame(20, 1'b1, 1'b1, 1'b0);
    settle();

    set_region(1, 0, 0, 4095, 4095);
    send_frame(5, 1'b1, 1'b1, 1'b0);
    settle();

    random_start = pixels_sent;
    random_done = 0;
    while (random_done < RANDOM_PIXELS) begin
      if (random_done < RANDOM_PIXELS / 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 86;
      end else if (random_done < 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 86;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_phase();
      random_done = pixels_sent - random_start;
    end

    drain();
    repeat (8) @(posedge clk);
    if (scores_pending != 0) $error("focus_score: %0d expected scores never came", scores_pending);
    $display("run: %0d pixel requests, %0d focus scores, %0d register settings",
             pixels_sent, scores_seen, settings_used);
    $display("run: input back-pressure held for %0d cycles", backpressure_cycles);
    if (error_count == 0 && scores_pending == 0) begin
      $display("roi_gradient_focus_measure_top: match");
    end else begin
      $display("roi_gradient_focus_measure_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rgfm_pkg.sv
sv/rgfm_linestore.sv
sv/rgfm_position.sv
sv/rgfm_accum.sv
sv/roi_gradient_focus_measure_top.sv
dv/rgfm_score_checker.sv
dv/tb_roi_gradient_focus_measure_top.sv
